// ===== hdl/cal_pkg.sv =====
`default_nettype none
package cal_pkg;

  // Fixed field widths of the ports.
  localparam int OP_W        = 3;
  localparam int UID_FIELD_W = 56;
  localparam int LEN_W       = 3;
  localparam int STATUS_W    = 4;
  localparam int COUNT_W     = 5;
  localparam int TIME_W      = 16;
  localparam int ELAPSED_W   = 17;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TIME_W;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_TIME = 2'd1;
  localparam logic [TIME_W-1:0] OPEN_TIME_RESET  = 16'd3000;
  localparam logic [TIME_W-1:0] REARM_TIME_RESET = 16'd5000;

  // Defaults of the top-level parameters.
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int UID_BYTES_DEF   = 7;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_ENROL  = 3'd1,
    OP_REVOKE = 3'd2,
    OP_LIST   = 3'd3,
    OP_MANUAL = 3'd4,
    OP_TICK   = 3'd5
  } cal_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED  = 4'd0,
    STAT_DENIED   = 4'd1,
    STAT_BUSY     = 4'd2,
    STAT_ENROLLED = 4'd3,
    STAT_PRESENT  = 4'd4,
    STAT_FULL     = 4'd5,
    STAT_REVOKED  = 4'd6,
    STAT_ABSENT   = 4'd7,
    STAT_ENTRY    = 4'd8,
    STAT_EMPTY    = 4'd9,
    STAT_MANUAL   = 4'd10,
    STAT_TICK     = 4'd11
  } cal_status_t;

  typedef struct packed {
    cal_op_t                op;
    logic [UID_FIELD_W-1:0] uid;
    logic [LEN_W-1:0]       len;
  } cal_cmd_t;

  typedef struct packed {
    cal_status_t            status;
    logic                   lock_on;
    logic                   reader_ready;
    logic [COUNT_W-1:0]     entry_count;
    logic [UID_FIELD_W-1:0] listed_uid;
    logic [LEN_W-1:0]       listed_length;
    logic                   last;
  } cal_result_t;

  // Identifier bits kept per entry: the configured byte count, capped by the port.
  function automatic int uid_bits(input int bytes);
    int b;
    b = 8 * bytes;
    return (b < UID_FIELD_W) ? b : UID_FIELD_W;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/card_allowlist_lock_controller_core.sv =====
`default_nettype none
// Channel   Handshake                 Payload
// input     start / busy              in_operation, in_uid_value, in_uid_length
// result    out_strobe (one cycle)    out_status ... out_last
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A transfer passes the front register and the command queue before the back end takes
// it up. A read, enrol or revoke scans the table from entry 0 until a hit or the entry
// count, and a revoke that hits then moves the later entries down one per cycle. A
// list strobes its entries in order from the first, one each cycle.
// Reset is synchronous and active low and leaves the table memory as it is. Results
// never stall; busy rises only when the front register and the command queue are full.
module card_allowlist_lock_controller_core #(
  parameter int TABLE_DEPTH = cal_pkg::TABLE_DEPTH_DEF,
  parameter int UID_BYTES   = cal_pkg::UID_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Command input
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [cal_pkg::OP_W-1:0]         in_operation,
  input  wire logic [cal_pkg::UID_FIELD_W-1:0]  in_uid_value,
  input  wire logic [cal_pkg::LEN_W-1:0]        in_uid_length,
  // Results
  output logic                                  out_strobe,
  output logic [cal_pkg::STATUS_W-1:0]          out_status,
  output logic                                  out_lock_on,
  output logic                                  out_reader_ready,
  output logic [cal_pkg::COUNT_W-1:0]           out_entry_count,
  output logic [cal_pkg::UID_FIELD_W-1:0]       out_listed_uid,
  output logic [cal_pkg::LEN_W-1:0]             out_listed_length,
  output logic                                  out_last,
  // Configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cal_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cal_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cal_pkg::*;

  logic [TIME_W-1:0] open_time_r, open_time_nxt;
  logic [TIME_W-1:0] rearm_time_r, rearm_time_nxt;

  logic        push, pop, queue_empty, queue_full;
  cal_cmd_t    push_data, head;
  logic        res_valid;
  cal_result_t res;

  // The configuration port is always ready: a transfer lands in the register at once,
  // and an index beyond the two registers is simply ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    open_time_nxt  = open_time_r;
    rearm_time_nxt = rearm_time_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OPEN_TIME:  open_time_nxt  = cfg_data;
        CFG_REARM_TIME: rearm_time_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_time_r  <= OPEN_TIME_RESET;
      rearm_time_r <= REARM_TIME_RESET;
    end else begin
      open_time_r  <= open_time_nxt;
      rearm_time_r <= rearm_time_nxt;
    end
  end

  // The front end takes each command, masks the identifier to the stored width and
  // drops codes that name no operation before placing the command in the queue.
  cal_front #(
    .UID_BYTES (UID_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_uid_value  (in_uid_value),
    .in_uid_length (in_uid_length),
    .queue_full    (queue_full),
    .push          (push),
    .push_data     (push_data)
  );

  // A short queue lets the front accept the next command while the back end is still
  // scanning or shifting the table.
  cal_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  // The back end owns the table memory, the entry count and both pulse timers, and
  // produces every result through a registered output stage.
  cal_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .UID_BYTES   (UID_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .queue_empty (queue_empty),
    .pop         (pop),
    .open_time   (open_time_r),
    .rearm_time  (rearm_time_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign out_strobe        = res_valid;
  assign out_status        = res.status;
  assign out_lock_on       = res.lock_on;
  assign out_reader_ready  = res.reader_ready;
  assign out_entry_count   = res.entry_count;
  assign out_listed_uid    = res.listed_uid;
  assign out_listed_length = res.listed_length;
  assign out_last          = res.last;

endmodule
`default_nettype wire

// ===== hdl/cal_ram.sv =====
`default_nettype none
module cal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cal_queue.sv =====
`default_nettype none
module cal_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cal_pkg::cal_cmd_t push_data,
  input  wire logic              pop,
  output cal_pkg::cal_cmd_t      head,
  output logic                   empty,
  output logic                   full
);
  import cal_pkg::*;

  cal_cmd_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     fill_r, fill_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (fill_r == '0);
  assign full  = (fill_r == (QPTR_W + 1)'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cal_front.sv =====
`default_nettype none
module cal_front #(
  parameter int UID_BYTES = cal_pkg::UID_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cal_pkg::OP_W-1:0]        in_operation,
  input  wire logic [cal_pkg::UID_FIELD_W-1:0] in_uid_value,
  input  wire logic [cal_pkg::LEN_W-1:0]       in_uid_length,
  input  wire logic                          queue_full,
  output logic                               push,
  output cal_pkg::cal_cmd_t                  push_data
);
  import cal_pkg::*;

  localparam int UID_W = uid_bits(UID_BYTES);
  localparam logic [UID_FIELD_W-1:0] UID_MASK = {UID_FIELD_W{1'b1}} >> (UID_FIELD_W - UID_W);

  logic     hold_valid_r, hold_valid_nxt;
  cal_cmd_t hold_cmd_r, hold_cmd_nxt;
  logic     accept;
  logic     legal;

  assign push      = hold_valid_r && !queue_full;
  assign busy      = hold_valid_r && queue_full;
  assign accept    = start && !busy;
  assign push_data = hold_cmd_r;

  // Codes outside the operation set are dropped here and never reach the back end.
  always_comb begin
    case (in_operation)
      OP_READ, OP_ENROL, OP_REVOKE, OP_LIST, OP_MANUAL, OP_TICK: legal = 1'b1;
      default: legal = 1'b0;
    endcase
  end

  always_comb begin
    hold_valid_nxt = push ? 1'b0 : hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (accept && legal) begin
      hold_valid_nxt   = 1'b1;
      hold_cmd_nxt.op  = cal_op_t'(in_operation);
      hold_cmd_nxt.uid = in_uid_value & UID_MASK;
      hold_cmd_nxt.len = in_uid_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_cmd_r <= hold_cmd_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/cal_back.sv =====
`default_nettype none
module cal_back #(
  parameter int TABLE_DEPTH = cal_pkg::TABLE_DEPTH_DEF,
  parameter int UID_BYTES   = cal_pkg::UID_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cal_pkg::cal_cmd_t        head,
  input  wire logic                     queue_empty,
  output logic                          pop,
  input  wire logic [cal_pkg::TIME_W-1:0] open_time,
  input  wire logic [cal_pkg::TIME_W-1:0] rearm_time,
  output logic                          res_valid,
  output cal_pkg::cal_result_t          res
);
  import cal_pkg::*;

  localparam int UID_W = uid_bits(UID_BYTES);
  localparam int ENT_W = UID_W + LEN_W;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_LIST  = 4'b1000
  } back_state_t;

  back_state_t            state_r, state_nxt;
  cal_cmd_t               cmd_r, cmd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       iss_r, iss_nxt;
  logic                   pend_r, pend_nxt;
  logic [CNT_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic                   lock_r, lock_nxt;
  logic                   rdr_busy_r, rdr_busy_nxt;
  logic [ELAPSED_W-1:0]   since_r, since_nxt;
  logic                   man_r, man_nxt;
  logic [ELAPSED_W-1:0]   man_el_r, man_el_nxt;
  logic                   res_valid_r, res_valid_nxt;
  cal_result_t            res_r, res_nxt;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [ENT_W-1:0]       ram_wdata, ram_rdata;

  logic [ENT_W-1:0]       key;
  logic                   hit;
  logic [CNT_W-1:0]       pend_inc, pend_dec;
  logic [ELAPSED_W-1:0]   since_inc, man_inc, open_ext, rearm_ext;
  logic [CNT_W+COUNT_W-1:0]     cnt_wide;
  logic [UID_W+UID_FIELD_W-1:0] ent_uid_wide;

  logic                   emit;
  cal_status_t            emit_status;
  logic [UID_FIELD_W-1:0] emit_uid;
  logic [LEN_W-1:0]       emit_len;
  logic                   emit_last;

  cal_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign key          = {cmd_r.uid[UID_W-1:0], cmd_r.len};
  assign hit          = pend_r && (ram_rdata == key);
  assign pend_inc     = pend_idx_r + 1'b1;
  assign pend_dec     = pend_idx_r - 1'b1;
  assign since_inc    = (since_r < ELAPSED_MAX) ? since_r + 1'b1 : since_r;
  assign man_inc      = (man_el_r < ELAPSED_MAX) ? man_el_r + 1'b1 : man_el_r;
  assign open_ext     = {1'b0, open_time};
  assign rearm_ext    = {1'b0, rearm_time};
  assign ent_uid_wide = {{UID_FIELD_W{1'b0}}, ram_rdata[ENT_W-1:LEN_W]};

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    iss_nxt      = iss_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    lock_nxt     = lock_r;
    rdr_busy_nxt = rdr_busy_r;
    since_nxt    = since_r;
    man_nxt      = man_r;
    man_el_nxt   = man_el_r;
    pop          = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r[IDX_W-1:0];
    ram_wdata    = key;
    ram_re       = 1'b0;
    ram_raddr    = iss_r[IDX_W-1:0];
    emit         = 1'b0;
    emit_status  = STAT_TICK;
    emit_uid     = '0;
    emit_len     = '0;
    emit_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (!queue_empty) begin
          pop      = 1'b1;
          cmd_nxt  = head;
          iss_nxt  = '0;
          pend_nxt = 1'b0;
          case (head.op)
            OP_READ: begin
              if (rdr_busy_r) begin
                emit        = 1'b1;
                emit_status = STAT_BUSY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_ENROL: begin
              if (cnt_r == DEPTH_CNT) begin
                emit        = 1'b1;
                emit_status = STAT_FULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_REVOKE: state_nxt = S_SCAN;
            OP_LIST: begin
              if (cnt_r == '0) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                state_nxt = S_LIST;
              end
            end
            OP_MANUAL: begin
              man_nxt     = 1'b1;
              man_el_nxt  = '0;
              emit        = 1'b1;
              emit_status = STAT_MANUAL;
            end
            OP_TICK: begin
              if (rdr_busy_r) begin
                if (since_inc > open_ext) begin
                  lock_nxt = 1'b0;
                end
                if (since_inc > rearm_ext) begin
                  rdr_busy_nxt = 1'b0;
                  lock_nxt     = 1'b0;
                  since_nxt    = '0;
                end else begin
                  since_nxt = since_inc;
                end
              end
              if (man_r) begin
                if (man_inc >= open_ext) begin
                  man_nxt    = 1'b0;
                  man_el_nxt = '0;
                end else begin
                  man_el_nxt = man_inc;
                end
              end
              emit        = 1'b1;
              emit_status = STAT_TICK;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit || (iss_r == cnt_r)) begin
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
          case (cmd_r.op)
            OP_READ: begin
              rdr_busy_nxt = 1'b1;
              since_nxt    = '0;
              emit         = 1'b1;
              if (hit) begin
                lock_nxt    = 1'b1;
                emit_status = STAT_GRANTED;
              end else begin
                emit_status = STAT_DENIED;
              end
            end
            OP_ENROL: begin
              emit = 1'b1;
              if (hit) begin
                emit_status = STAT_PRESENT;
              end else begin
                ram_we      = 1'b1;
                cnt_nxt     = cnt_r + 1'b1;
                emit_status = STAT_ENROLLED;
              end
            end
            OP_REVOKE: begin
              if (hit) begin
                state_nxt = S_SHIFT;
                iss_nxt   = pend_inc;
              end else begin
                emit        = 1'b1;
                emit_status = STAT_ABSENT;
              end
            end
            default: begin
            end
          endcase
        end else begin
          ram_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_r;
          iss_nxt      = iss_r + 1'b1;
        end
      end

      S_SHIFT: begin
        // Each entry read in the cycle before is written one place lower.
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_dec[IDX_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (iss_r == cnt_r) begin
          pend_nxt    = 1'b0;
          cnt_nxt     = cnt_r - 1'b1;
          emit        = 1'b1;
          emit_status = STAT_REVOKED;
          state_nxt   = S_IDLE;
        end else begin
          ram_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_r;
          iss_nxt      = iss_r + 1'b1;
        end
      end

      S_LIST: begin
        pend_nxt = 1'b0;
        if (pend_r) begin
          emit        = 1'b1;
          emit_status = STAT_ENTRY;
          emit_uid    = ent_uid_wide[UID_FIELD_W-1:0];
          emit_len    = ram_rdata[LEN_W-1:0];
          emit_last   = (pend_inc == cnt_r);
          if (pend_inc == cnt_r) begin
            state_nxt = S_IDLE;
          end
        end
        if (iss_r != cnt_r) begin
          ram_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_r;
          iss_nxt      = iss_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cnt_wide = {{COUNT_W{1'b0}}, cnt_nxt};

  always_comb begin
    res_valid_nxt         = emit;
    res_nxt.status        = emit_status;
    res_nxt.lock_on       = lock_nxt || man_nxt;
    res_nxt.reader_ready  = !rdr_busy_nxt;
    res_nxt.entry_count   = cnt_wide[COUNT_W-1:0];
    res_nxt.listed_uid    = emit_uid;
    res_nxt.listed_length = emit_len;
    res_nxt.last          = emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      lock_r      <= 1'b0;
      rdr_busy_r  <= 1'b0;
      since_r     <= '0;
      man_r       <= 1'b0;
      man_el_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      lock_r      <= lock_nxt;
      rdr_busy_r  <= rdr_busy_nxt;
      since_r     <= since_nxt;
      man_r       <= man_nxt;
      man_el_r    <= man_el_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
// Testbench for the card allowlist lock controller.
//
// Commands go in through the start/busy port. The block never holds results
// back: each one appears for a single cycle under out_strobe. The driver
// below checks each transfer at the clock edge. At every accepted command it
// runs the allowlist predictor, which keeps its own copy of the table, the
// lock timers and both timing registers, and queues the results the command
// should produce. The monitor takes every strobed result off the front of that
// queue and compares it field by field.
module tb_top;
  import cal_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int POOL_SIZE    = 8;
  // Settling margin: a revoke of the first of sixteen entries needs a scan and
  // a shift. Up to four commands can be held inside.
  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 200000;

  // Operation codes that the block must swallow without any result.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic [OP_W-1:0]        op;
    logic [UID_FIELD_W-1:0] uid;
    logic [LEN_W-1:0]       len;
    int unsigned            gap;        // idle cycles in front of this command
    bit                     wait_drain; // hold it back until all results are in
  } card_cmd_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   start         = 1'b0;
  logic                   busy;
  logic [OP_W-1:0]        in_operation  = '0;
  logic [UID_FIELD_W-1:0] in_uid_value  = '0;
  logic [LEN_W-1:0]       in_uid_length = '0;

  logic                   out_strobe;
  logic [STATUS_W-1:0]    out_status;
  logic                   out_lock_on;
  logic                   out_reader_ready;
  logic [COUNT_W-1:0]     out_entry_count;
  logic [UID_FIELD_W-1:0] out_listed_uid;
  logic [LEN_W-1:0]       out_listed_length;
  logic                   out_last;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  card_allowlist_lock_controller_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_uid_value      (in_uid_value),
    .in_uid_length     (in_uid_length),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_lock_on       (out_lock_on),
    .out_reader_ready  (out_reader_ready),
    .out_entry_count   (out_entry_count),
    .out_listed_uid    (out_listed_uid),
    .out_listed_length (out_listed_length),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Allowlist predictor. The state mirrors the block after every command.
  // ---------------------------------------------------------------------------
  logic [UID_FIELD_W-1:0] acl_uid [TABLE_DEPTH];
  logic [LEN_W-1:0]       acl_len [TABLE_DEPTH];
  logic [COUNT_W-1:0]     acl_count     = '0;
  logic                   coil_card     = 1'b0;  // lock pulse after a grant
  logic                   coil_manual   = 1'b0;  // lock pulse after a manual open
  logic                   reader_locked = 1'b0;  // reader waits for re-arm
  logic [ELAPSED_W-1:0]   ms_since_read = '0;
  logic [ELAPSED_W-1:0]   ms_manual     = '0;
  logic [TIME_W-1:0]      open_ms       = OPEN_TIME_RESET;
  logic [TIME_W-1:0]      rearm_ms      = REARM_TIME_RESET;

  cal_result_t awaited_results[$];
  int          results_owed = 0;  // results predicted so far (driver side)
  int          results_seen = 0;  // results strobed so far (monitor side)
  int          errors       = 0;

  card_cmd_t   cmd_queue[$];
  int unsigned idle_count  = 0;
  int          no_idle_run = 0;
  int          cycle_count = 0;

  logic [UID_FIELD_W-1:0] pool_uid [POOL_SIZE];
  logic [LEN_W-1:0]       pool_len [POOL_SIZE];

  // An identifier matches only when both the value and the byte count agree.
  function automatic int find_card(input logic [UID_FIELD_W-1:0] uid,
                                   input logic [LEN_W-1:0] len);
    for (int i = 0; i < acl_count; i++) begin
      if (acl_uid[i] == uid && acl_len[i] == len) return i;
    end
    return -1;
  endfunction

  // The flags in a result always reflect the state after the command.
  function automatic void post_result(input cal_status_t st,
                                      input logic [UID_FIELD_W-1:0] uid,
                                      input logic [LEN_W-1:0] len,
                                      input logic fin);
    cal_result_t r;
    r.status        = st;
    r.lock_on       = coil_card | coil_manual;
    r.reader_ready  = ~reader_locked;
    r.entry_count   = acl_count;
    r.listed_uid    = uid;
    r.listed_length = len;
    r.last          = fin;
    awaited_results.push_back(r);
    results_owed++;
  endfunction

  function automatic void step_allowlist(input logic [OP_W-1:0] op,
                                         input logic [UID_FIELD_W-1:0] uid,
                                         input logic [LEN_W-1:0] len);
    int hit;
    hit = find_card(uid, len);
    case (op)
      OP_READ: begin
        // Reads are dropped while the reader is still waiting to re-arm.
        if (reader_locked) begin
          post_result(STAT_BUSY, '0, '0, 1'b1);
        end else begin
          reader_locked = 1'b1;
          ms_since_read = '0;
          if (hit >= 0) begin
            coil_card = 1'b1;
            post_result(STAT_GRANTED, '0, '0, 1'b1);
          end else begin
            post_result(STAT_DENIED, '0, '0, 1'b1);
          end
        end
      end
      OP_ENROL: begin
        // Capacity is checked before the duplicate search.
        if (acl_count >= TABLE_DEPTH) begin
          post_result(STAT_FULL, '0, '0, 1'b1);
        end else if (hit >= 0) begin
          post_result(STAT_PRESENT, '0, '0, 1'b1);
        end else begin
          acl_uid[acl_count] = uid;
          acl_len[acl_count] = len;
          acl_count++;
          post_result(STAT_ENROLLED, '0, '0, 1'b1);
        end
      end
      OP_REVOKE: begin
        if (hit < 0) begin
          post_result(STAT_ABSENT, '0, '0, 1'b1);
        end else begin
          for (int i = hit; i + 1 < acl_count; i++) begin
            acl_uid[i] = acl_uid[i+1];
            acl_len[i] = acl_len[i+1];
          end
          acl_count--;
          post_result(STAT_REVOKED, '0, '0, 1'b1);
        end
      end
      OP_LIST: begin
        if (acl_count == 0) begin
          post_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < acl_count; i++) begin
            post_result(STAT_ENTRY, acl_uid[i], acl_len[i], i + 1 == acl_count);
          end
        end
      end
      OP_MANUAL: begin
        // A manual open restarts its pulse, even while one is running.
        coil_manual = 1'b1;
        ms_manual   = '0;
        post_result(STAT_MANUAL, '0, '0, 1'b1);
      end
      OP_TICK: begin
        // The card pulse ends once the count passes the open time; the reader
        // re-arms once it passes the rearm time. Both compare strictly.
        if (reader_locked) begin
          if (ms_since_read != ELAPSED_MAX) ms_since_read++;
          if (ms_since_read > open_ms) coil_card = 1'b0;
          if (ms_since_read > rearm_ms) begin
            reader_locked = 1'b0;
            coil_card     = 1'b0;
            ms_since_read = '0;
          end
        end
        // The manual pulse ends as soon as its count reaches the open time.
        if (coil_manual) begin
          if (ms_manual != ELAPSED_MAX) ms_manual++;
          if (ms_manual >= open_ms) begin
            coil_manual = 1'b0;
            ms_manual   = '0;
          end
        end
        post_result(STAT_TICK, '0, '0, 1'b1);
      end
      default: begin
        // Spare operation codes leave no trace at all.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A command transfer happens at an edge with start high and busy
  // low. The next command, if its gap has run out, is put on the port at the
  // same edge, so start is only ever assigned once per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    logic      fire;
    card_cmd_t nxt;
    if (rst_n) begin
      fire = start && !busy;
      if (fire) step_allowlist(in_operation, in_uid_value, in_uid_length);
      if (!start || fire) begin
        if (!start) idle_count++;
        // results_seen is updated with a nonblocking assignment, so this view
        // trails the monitor by one update at most and a drained block is never missed.
        if (cmd_queue.size() != 0 && idle_count >= cmd_queue[0].gap &&
            !(cmd_queue[0].wait_drain && results_owed != results_seen)) begin
          nxt = cmd_queue.pop_front();
          start         <= 1'b1;
          in_operation  <= nxt.op;
          in_uid_value  <= nxt.uid;
          in_uid_length <= nxt.len;
          idle_count    = 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every strobed result is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    cal_result_t want;
    if (rst_n && out_strobe) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 out_status);
      end else begin
        want = awaited_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("lock_on", want.lock_on, out_lock_on);
        check_field("reader_ready", want.reader_ready, out_reader_ready);
        check_field("entry_count", want.entry_count, out_entry_count);
        check_field("listed_uid", want.listed_uid, out_listed_uid);
        check_field("listed_length", want.listed_length, out_listed_length);
        check_field("last", want.last, out_last);
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [UID_FIELD_W-1:0] random_uid();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[UID_FIELD_W-1:0];
  endfunction

  // The sender may idle before each command, apart from runs of
  // back-to-back transfers that keep the command queue inside the block full.
  function automatic void queue_cmd(input logic [OP_W-1:0] op,
                                    input logic [UID_FIELD_W-1:0] uid,
                                    input logic [LEN_W-1:0] len,
                                    input bit wait_drain);
    card_cmd_t c;
    c.op = op;
    c.uid = uid;
    c.len = len;
    c.wait_drain = wait_drain;
    if (no_idle_run > 0) begin
      c.gap = 0;
      no_idle_run--;
    end else begin
      c.gap = $urandom_range(0, 4);
      if ($urandom_range(0, 11) == 0) no_idle_run = $urandom_range(5, 15);
    end
    cmd_queue.push_back(c);
  endfunction

  // The first four cards are fixed corner cases: all ones, zero with byte counts
  // of 0 and 1, and 0x12345678. The rest are redrawn, two of them sharing a value
  // but differing in length so that only the length tells them apart.
  function automatic void refill_pool();
    pool_uid[0] = '1;                pool_len[0] = 3'd7;
    pool_uid[1] = '0;                pool_len[1] = 3'd0;
    pool_uid[2] = '0;                pool_len[2] = 3'd1;
    pool_uid[3] = 56'h0000_0012_3456_78; pool_len[3] = 3'd4;
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool_uid[i] = random_uid();
      pool_len[i] = LEN_W'($urandom_range(0, 7));
    end
    pool_uid[5] = pool_uid[4];
    pool_len[5] = pool_len[4] + 3'd1;
  endfunction

  // Mostly cards from the pool so that reads grant and revokes find entries;
  // ticks are frequent enough that the reader re-arms often.
  function automatic void queue_random_cmds(input int n);
    int                     r;
    int                     k;
    logic [OP_W-1:0]        op;
    logic [UID_FIELD_W-1:0] uid;
    logic [LEN_W-1:0]       len;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if      (r < 38) op = OP_TICK;
      else if (r < 56) op = OP_READ;
      else if (r < 70) op = OP_ENROL;
      else if (r < 80) op = OP_REVOKE;
      else if (r < 87) op = OP_LIST;
      else if (r < 95) op = OP_MANUAL;
      else if (r < 97) op = OP_SPARE_A;
      else             op = OP_SPARE_B;
      if ($urandom_range(0, 3) != 0) begin
        k   = $urandom_range(0, POOL_SIZE - 1);
        uid = pool_uid[k];
        len = pool_len[k];
      end else begin
        uid = random_uid();
        len = LEN_W'($urandom_range(0, 7));
      end
      queue_cmd(op, uid, len, 1'b0);
    end
  endfunction

  // Idle means every command transferred, every result back, and then a
  // latency margin for commands such as the spare codes that return nothing.
  task automatic wait_for_idle();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || start || results_owed != results_seen);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_OPEN_TIME) open_ms = val;
    else if (idx == CFG_REARM_TIME) rearm_ms = val;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [UID_FIELD_W-1:0] fresh_uid[$];
    logic [UID_FIELD_W-1:0] u;
    int                     room;

    refill_pool();

    // Directed commands with the registers at their reset values. The reader
    // grants once and then stays disarmed for the rest of this phase.
    queue_cmd(OP_LIST, '0, '0, 1'b0);                       // empty table
    for (int i = 0; i < 4; i++) queue_cmd(OP_ENROL, pool_uid[i], pool_len[i], 1'b0);
    queue_cmd(OP_ENROL, pool_uid[0], pool_len[0], 1'b0);    // duplicate
    queue_cmd(OP_LIST, '1, 3'd7, 1'b0);
    queue_cmd(OP_READ, pool_uid[0], pool_len[0], 1'b0);     // granted
    queue_cmd(OP_READ, pool_uid[2], pool_len[2], 1'b0);     // ignored while disarmed
    queue_cmd(OP_TICK, '0, '0, 1'b0);
    queue_cmd(OP_MANUAL, '1, 3'd7, 1'b0);
    queue_cmd(OP_TICK, '1, 3'd7, 1'b0);
    queue_cmd(OP_MANUAL, '0, '0, 1'b0);                     // restarts the pulse
    queue_cmd(OP_REVOKE, pool_uid[1], pool_len[1], 1'b0);   // middle entry, shift
    queue_cmd(OP_REVOKE, pool_uid[1], pool_len[1], 1'b0);   // now absent
    queue_cmd(OP_REVOKE, pool_uid[0], 3'd6, 1'b0);          // right value, wrong length
    queue_cmd(OP_SPARE_A, pool_uid[0], pool_len[0], 1'b0);
    queue_cmd(OP_SPARE_B, '1, 3'd7, 1'b0);
    queue_cmd(OP_LIST, '0, '0, 1'b0);
    wait_for_idle();

    // Short timings: the reader re-arms after a few ticks, then a read of an
    // unknown card is denied.
    write_reg(CFG_OPEN_TIME, 16'd1);
    write_reg(CFG_REARM_TIME, 16'd2);
    @(negedge clk);
    refill_pool();
    repeat (3) queue_cmd(OP_TICK, random_uid(), LEN_W'($urandom_range(0, 7)), 1'b0);
    queue_cmd(OP_READ, random_uid(), 3'd5, 1'b0);
    queue_random_cmds(50);
    wait_for_idle();

    // Lowest settings: every pulse and every wait ends on the first tick. The
    // spare register indexes are written as well and must change nothing.
    write_reg(CFG_OPEN_TIME, 16'd0);
    write_reg(CFG_REARM_TIME, 16'd0);
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
    write_reg(CFG_SPARE_B, 16'hFFFF);
    @(negedge clk);
    refill_pool();
    queue_random_cmds(35);
    wait_for_idle();

    // Highest settings, with the table filled to capacity. Enrolling a card,
    // present or not, must still answer full.
    write_reg(CFG_OPEN_TIME, 16'hFFFF);
    write_reg(CFG_REARM_TIME, 16'hFFFF);
    @(negedge clk);
    room = TABLE_DEPTH - acl_count;
    for (int i = 0; i < room; i++) begin
      u = random_uid();
      fresh_uid.push_back(u);
      queue_cmd(OP_ENROL, u, 3'd7, 1'b0);
    end
    queue_cmd(OP_ENROL, pool_uid[0], pool_len[0], 1'b0);
    queue_cmd(OP_ENROL, random_uid(), 3'd4, 1'b0);
    queue_cmd(OP_LIST, '0, '0, 1'b0);
    if (fresh_uid.size() != 0) begin
      queue_cmd(OP_REVOKE, fresh_uid[0], 3'd7, 1'b0);
      queue_cmd(OP_REVOKE, fresh_uid[fresh_uid.size()-1], 3'd7, 1'b0);
    end
    queue_cmd(OP_LIST, '0, '0, 1'b0);
    queue_random_cmds(15);
    wait_for_idle();

    // Random moderate timings. Half way through, the sender holds off until
    // every outstanding result has come back.
    write_reg(CFG_OPEN_TIME, CFG_DATA_W'($urandom_range(1, 6)));
    write_reg(CFG_REARM_TIME, CFG_DATA_W'($urandom_range(2, 10)));
    @(negedge clk);
    refill_pool();
    queue_random_cmds(20);
    queue_cmd(OP_LIST, '0, '0, 1'b1);
    queue_random_cmds(25);
    wait_for_idle();

    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               awaited_results.size());
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
